>>> rtl/tsi_pkg.sv
// ----------------------------------------------------------------------------
// tsi_pkg: shared constants and types of the touch stroke interpolator
// Coordinate and time widths, register map, register reset values and the
// configuration bundle passed from the register block to the datapath.
// ----------------------------------------------------------------------------
package tsi_pkg;

   localparam int CoordBits    = 9;
   localparam int MaxSteps     = 63;
   localparam int StepBits     = $clog2(MaxSteps + 1);
   localparam int TimeBits     = 32;
   localparam int TimeoutBits  = 16;
   localparam int SpacingBits  = 4;
   localparam int DivCountBits = $clog2(CoordBits + 1);

   localparam int CsrDataBits  = 32;
   localparam int CsrAddrBits  = 5;
   localparam int CsrIndexBits = CsrAddrBits - 2;

   localparam logic [TimeoutBits-1:0] TimeoutReset  = TimeoutBits'(200);
   localparam logic [CoordBits-1:0]   LeftReset     = CoordBits'(0);
   localparam logic [CoordBits-1:0]   TopReset      = CoordBits'(430);
   localparam logic [CoordBits-1:0]   WidthReset    = CoordBits'(222);
   localparam logic [CoordBits-1:0]   HeightReset   = CoordBits'(50);
   localparam logic [SpacingBits-1:0] SpacingReset  = SpacingBits'(2);

   typedef enum logic [CsrIndexBits-1:0] {
      REG_TIMEOUT = CsrIndexBits'(0),
      REG_LEFT    = CsrIndexBits'(1),
      REG_TOP     = CsrIndexBits'(2),
      REG_WIDTH   = CsrIndexBits'(3),
      REG_HEIGHT  = CsrIndexBits'(4),
      REG_SPACING = CsrIndexBits'(5)
   } csr_reg_type;

   typedef enum logic {
      CMD_DOT   = 1'b0,
      CMD_CLEAR = 1'b1
   } command_type;

   typedef struct packed {
      logic [TimeoutBits-1:0] session_timeout_ms;
      logic [CoordBits-1:0]   button_left;
      logic [CoordBits-1:0]   button_top;
      logic [CoordBits-1:0]   button_width;
      logic [CoordBits-1:0]   button_height;
      logic [SpacingBits-1:0] dot_spacing;
   } cfg_type;

endpackage

>>> rtl/tsi_csr.sv
// ----------------------------------------------------------------------------
// tsi_csr: configuration register block
// Holds the session timeout, clear button rectangle and dot spacing behind an
// APB-style port that never stalls, with csr_pready tied high.
// ----------------------------------------------------------------------------
module tsi_csr
   import tsi_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CsrAddrBits-1:0] csr_paddr,
   input  logic [CsrDataBits-1:0] csr_pwdata,
   output logic [CsrDataBits-1:0] csr_prdata,
   output logic                   csr_pready,
   output cfg_type                cfg
);

   cfg_type                  cfg_ff;
   cfg_type                  cfg_in;
   logic                     write_en;
   logic [CsrIndexBits-1:0]  index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign index      = csr_paddr[CsrAddrBits-1:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_TIMEOUT: cfg_in.session_timeout_ms = csr_pwdata[TimeoutBits-1:0];
            REG_LEFT:    cfg_in.button_left        = csr_pwdata[CoordBits-1:0];
            REG_TOP:     cfg_in.button_top         = csr_pwdata[CoordBits-1:0];
            REG_WIDTH:   cfg_in.button_width       = csr_pwdata[CoordBits-1:0];
            REG_HEIGHT:  cfg_in.button_height      = csr_pwdata[CoordBits-1:0];
            REG_SPACING: cfg_in.dot_spacing        = csr_pwdata[SpacingBits-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_TIMEOUT: csr_prdata = CsrDataBits'(cfg_ff.session_timeout_ms);
         REG_LEFT:    csr_prdata = CsrDataBits'(cfg_ff.button_left);
         REG_TOP:     csr_prdata = CsrDataBits'(cfg_ff.button_top);
         REG_WIDTH:   csr_prdata = CsrDataBits'(cfg_ff.button_width);
         REG_HEIGHT:  csr_prdata = CsrDataBits'(cfg_ff.button_height);
         REG_SPACING: csr_prdata = CsrDataBits'(cfg_ff.dot_spacing);
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.session_timeout_ms <= TimeoutReset;
         cfg_ff.button_left        <= LeftReset;
         cfg_ff.button_top         <= TopReset;
         cfg_ff.button_width       <= WidthReset;
         cfg_ff.button_height      <= HeightReset;
         cfg_ff.dot_spacing        <= SpacingReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/tsi_div.sv
// ----------------------------------------------------------------------------
// tsi_div: bit-serial restoring divider
// Shifts the dividend in one bit per cycle, most significant first, and
// shifts the quotient bits back into the same register.
// ----------------------------------------------------------------------------
module tsi_div
   import tsi_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [CoordBits-1:0] num,
   input  logic [CoordBits-1:0] den,
   output logic                 done,
   output logic [CoordBits-1:0] quot,
   output logic [CoordBits-1:0] rem
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DivCountBits-1:0] cnt_ff, cnt_in;
   logic [CoordBits-1:0]    work_ff, work_in;
   logic [CoordBits-1:0]    rem_ff, rem_in;
   logic [CoordBits-1:0]    den_ff, den_in;
   logic [CoordBits:0]      trial;
   logic                    fits;

   assign trial = {rem_ff, work_ff[CoordBits-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DivCountBits'(CoordBits);
         work_in = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in  = fits ? CoordBits'(trial - {1'b0, den_ff}) : trial[CoordBits-1:0];
         work_in = {work_ff[CoordBits-2:0], fits};
         cnt_in  = cnt_ff - DivCountBits'(1);
         if (cnt_ff == DivCountBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quot = work_ff;
   assign rem  = rem_ff;

endmodule

>>> rtl/touch_stroke_interpolator_core.sv
// ----------------------------------------------------------------------------
// touch_stroke_interpolator_core: turns touch reports into dot and clear words
// A single dot or clear word is registered via ST_DECIDE and ST_SINGLE.
// A continued stroke runs three serial divisions (steps, x and y), then
// gives steps + 1 dots, one per cycle while the output register is free.
// One report is worked on at a time; the next is taken once the last word
// is in the output register. Reset clears the stroke state and restores the
// register defaults at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module touch_stroke_interpolator_core
   import tsi_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [CoordBits-1:0]   req_touch_x,
   input  logic [CoordBits-1:0]   req_touch_y,
   input  logic [TimeBits-1:0]    req_time_ms,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_command,
   output logic [CoordBits-1:0]   rsp_dot_x,
   output logic [CoordBits-1:0]   rsp_dot_y,
   output logic                   rsp_last_of_run,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CsrAddrBits-1:0] csr_paddr,
   input  logic [CsrDataBits-1:0] csr_pwdata,
   output logic [CsrDataBits-1:0] csr_prdata,
   output logic                   csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SPAN,
      ST_DIV_STEPS,
      ST_DIV_X,
      ST_DIV_Y,
      ST_SINGLE,
      ST_EMIT
   } state_type;

   cfg_type cfg;

   state_type             state_ff, state_in;
   logic [CoordBits-1:0]  x_ff, x_in, y_ff, y_in;
   logic [TimeBits-1:0]   gap_ff, gap_in, last_time_ff, last_time_in;
   logic [CoordBits-1:0]  prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic                  active_ff, active_in;
   logic                  neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [CoordBits-1:0]  ax_ff, ax_in, ay_ff, ay_in;
   logic [StepBits-1:0]   steps_ff, steps_in;
   logic [CoordBits-1:0]  qa_x_ff, qa_x_in, qa_y_ff, qa_y_in;
   logic [StepBits-1:0]   ra_x_ff, ra_x_in, ra_y_ff, ra_y_in;
   logic [StepBits-1:0]   i_ff, i_in;
   logic [CoordBits-1:0]  qx_ff, qx_in, qy_ff, qy_in;
   logic [StepBits-1:0]   rx_ff, rx_in, ry_ff, ry_in;
   logic                  clear_ff, clear_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_cmd_ff, rsp_cmd_in;
   logic [CoordBits-1:0]  rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  div_start, div_done;
   logic [CoordBits-1:0]  div_num, div_den, div_quot, div_rem;

   logic                  same_session, in_button, out_free;
   logic [CoordBits:0]    right_edge, bottom_edge;
   logic [CoordBits-1:0]  span, spacing;
   logic [StepBits-1:0]   steps_sat;
   logic [StepBits:0]     rsum_x, rsum_y;
   logic                  wrap_x, wrap_y, last_dot;
   logic [CoordBits-1:0]  lerp_x, lerp_y;

   tsi_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tsi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   // The gap is registered at accept, so only the short compare is done here.
   assign same_session = (gap_ff[TimeBits-1:TimeoutBits] == '0) &&
                         (gap_ff[TimeoutBits-1:0] < cfg.session_timeout_ms);
   assign right_edge   = {1'b0, cfg.button_left} + {1'b0, cfg.button_width};
   assign bottom_edge  = {1'b0, cfg.button_top} + {1'b0, cfg.button_height};
   assign in_button    = (x_ff >= cfg.button_left) && ({1'b0, x_ff} < right_edge) &&
                         (y_ff >= cfg.button_top) && ({1'b0, y_ff} < bottom_edge);

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign span     = (ax_ff > ay_ff) ? ax_ff : ay_ff;
   assign spacing  = (cfg.dot_spacing == '0) ? CoordBits'(1) : CoordBits'(cfg.dot_spacing);

   assign steps_sat = (div_quot == '0) ? StepBits'(1) :
                      (div_quot > CoordBits'(MaxSteps)) ? StepBits'(MaxSteps) :
                      div_quot[StepBits-1:0];

   // Each dot advances the quotient by ax/steps and carries the remainder.
   assign rsum_x = {1'b0, rx_ff} + {1'b0, ra_x_ff};
   assign rsum_y = {1'b0, ry_ff} + {1'b0, ra_y_ff};
   assign wrap_x = rsum_x >= {1'b0, steps_ff};
   assign wrap_y = rsum_y >= {1'b0, steps_ff};
   assign last_dot = (i_ff == steps_ff);
   assign lerp_x = neg_x_ff ? prev_x_ff - qx_ff : prev_x_ff + qx_ff;
   assign lerp_y = neg_y_ff ? prev_y_ff - qy_ff : prev_y_ff + qy_ff;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      gap_in       = gap_ff;
      last_time_in = last_time_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      active_in    = active_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      steps_in     = steps_ff;
      qa_x_in      = qa_x_ff;
      ra_x_in      = ra_x_ff;
      qa_y_in      = qa_y_ff;
      ra_y_in      = ra_y_ff;
      i_in         = i_ff;
      qx_in        = qx_ff;
      rx_in        = rx_ff;
      qy_in        = qy_ff;
      ry_in        = ry_ff;
      clear_in     = clear_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_cmd_in   = rsp_cmd_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;
      div_start    = 1'b0;
      div_num      = ax_ff;
      div_den      = CoordBits'(steps_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in         = req_touch_x;
               y_in         = req_touch_y;
               gap_in       = req_time_ms - last_time_ff;
               last_time_in = req_time_ms;
               state_in     = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            neg_x_in = x_ff < prev_x_ff;
            neg_y_in = y_ff < prev_y_ff;
            ax_in    = (x_ff < prev_x_ff) ? prev_x_ff - x_ff : x_ff - prev_x_ff;
            ay_in    = (y_ff < prev_y_ff) ? prev_y_ff - y_ff : y_ff - prev_y_ff;
            if (in_button) begin
               active_in = 1'b0;
               clear_in  = 1'b1;
               state_in  = same_session ? ST_IDLE : ST_SINGLE;
            end else if (same_session && active_ff) begin
               state_in = ST_SPAN;
            end else begin
               clear_in  = 1'b0;
               prev_x_in = x_ff;
               prev_y_in = y_ff;
               active_in = 1'b1;
               state_in  = ST_SINGLE;
            end
         end
         ST_SPAN: begin
            div_start = 1'b1;
            div_num   = span;
            div_den   = spacing;
            state_in  = ST_DIV_STEPS;
         end
         ST_DIV_STEPS: begin
            if (div_done) begin
               steps_in  = steps_sat;
               div_start = 1'b1;
               div_num   = ax_ff;
               div_den   = CoordBits'(steps_sat);
               state_in  = ST_DIV_X;
            end
         end
         ST_DIV_X: begin
            if (div_done) begin
               qa_x_in   = div_quot;
               ra_x_in   = div_rem[StepBits-1:0];
               div_start = 1'b1;
               div_num   = ay_ff;
               div_den   = CoordBits'(steps_ff);
               state_in  = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (div_done) begin
               qa_y_in  = div_quot;
               ra_y_in  = div_rem[StepBits-1:0];
               i_in     = '0;
               qx_in    = '0;
               rx_in    = '0;
               qy_in    = '0;
               ry_in    = '0;
               state_in = ST_EMIT;
            end
         end
         ST_SINGLE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_cmd_in   = clear_ff ? CMD_CLEAR : CMD_DOT;
               rsp_x_in     = clear_ff ? '0 : x_ff;
               rsp_y_in     = clear_ff ? '0 : y_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_cmd_in   = CMD_DOT;
               rsp_x_in     = lerp_x;
               rsp_y_in     = lerp_y;
               rsp_last_in  = last_dot;
               if (last_dot) begin
                  prev_x_in = x_ff;
                  prev_y_in = y_ff;
                  active_in = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  i_in  = i_ff + StepBits'(1);
                  qx_in = qx_ff + qa_x_ff + CoordBits'(wrap_x);
                  rx_in = wrap_x ? StepBits'(rsum_x - {1'b0, steps_ff}) : rsum_x[StepBits-1:0];
                  qy_in = qy_ff + qa_y_ff + CoordBits'(wrap_y);
                  ry_in = wrap_y ? StepBits'(rsum_y - {1'b0, steps_ff}) : rsum_y[StepBits-1:0];
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         last_time_ff <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         active_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_time_ff <= last_time_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         active_ff    <= active_in;
      end
      x_ff        <= x_in;
      y_ff        <= y_in;
      gap_ff      <= gap_in;
      neg_x_ff    <= neg_x_in;
      neg_y_ff    <= neg_y_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      steps_ff    <= steps_in;
      qa_x_ff     <= qa_x_in;
      ra_x_ff     <= ra_x_in;
      qa_y_ff     <= qa_y_in;
      ra_y_ff     <= ra_y_in;
      i_ff        <= i_in;
      qx_ff       <= qx_in;
      rx_ff       <= rx_in;
      qy_ff       <= qy_in;
      ry_ff       <= ry_in;
      clear_ff    <= clear_in;
      rsp_cmd_ff  <= rsp_cmd_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_command     = rsp_cmd_ff;
   assign rsp_dot_x       = rsp_x_ff;
   assign rsp_dot_y       = rsp_y_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // The carried remainders must stay below the step count while dots go out.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (rx_ff < steps_ff) && (ry_ff < steps_ff))
      else $error("interpolation remainder out of range");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |->
         (steps_ff != '0) && (steps_ff <= StepBits'(MaxSteps)) && (i_ff <= steps_ff))
      else $error("step count or dot index out of range");

   assert property (@(posedge clock) disable iff (reset)
      div_done |->
         (state_ff == ST_DIV_STEPS) || (state_ff == ST_DIV_X) || (state_ff == ST_DIV_Y))
      else $error("divider finished outside a division state");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && out_free && last_dot |=>
         (state_ff == ST_IDLE) && active_ff && rsp_valid && rsp_last_of_run)
      else $error("stroke run did not close on its final dot");

endmodule
